[hdl/rplc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Register poll loop classifier package
// Shared constants, types and the address classification function.
// ----------------------------------------------------------------------------
package rplc_pkg;

  // History depth and derived widths.
  localparam int unsigned WINDOW   = 16;
  localparam int unsigned SLOT_W   = $clog2(WINDOW);
  localparam int unsigned CNT_W    = $clog2(WINDOW + 1);
  localparam int unsigned ADDR_W   = 32;
  localparam int unsigned MIN_FILL = 4;

  // Queue between the front and back parts.
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Device block spans in bytes, one bit wider than an address.
  localparam logic [ADDR_W:0] CDROM_SPAN      = (ADDR_W + 1)'(4);
  localparam logic [ADDR_W:0] CONTROLLER_SPAN = (ADDR_W + 1)'(16);
  localparam logic [ADDR_W:0] MDEC_SPAN       = (ADDR_W + 1)'(8);
  localparam logic [ADDR_W:0] DMA_SPAN        = (ADDR_W + 1)'(128);

  // Configuration register reset values.
  localparam logic [ADDR_W-1:0] CD_BLOCK_RST     = 32'd528488448;
  localparam logic [ADDR_W-1:0] CTRL_BASE_RST    = 32'd528486464;
  localparam logic [ADDR_W-1:0] DEC_BLOCK_RST    = 32'd528488480;
  localparam logic [ADDR_W-1:0] GPU_CMD_RST      = 32'd528488464;
  localparam logic [ADDR_W-1:0] GPU_CTRL_RST     = 32'd528488468;
  localparam logic [ADDR_W-1:0] DMA_BLOCK_RST    = 32'd528486528;
  localparam logic [ADDR_W-1:0] IRQ_STATUS_RST   = 32'd528486512;
  localparam logic [ADDR_W-1:0] IRQ_MASK_RST     = 32'd528486516;

  // Item kinds.
  typedef enum logic {
    KIND_ACCESS = 1'b0,
    KIND_CLEAR  = 1'b1
  } kind_e;

  // Stall reasons.
  typedef enum logic [2:0] {
    REASON_UNKNOWN    = 3'd0,
    REASON_CDROM      = 3'd1,
    REASON_CONTROLLER = 3'd2,
    REASON_DECODER    = 3'd3,
    REASON_GPU_BUSY   = 3'd4,
    REASON_DMA_WAIT   = 3'd5,
    REASON_IRQ        = 3'd6
  } reason_e;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_CD_BLOCK    = 3'd0,
    REG_PAD_BLOCK   = 3'd1,
    REG_DEC_BLOCK   = 3'd2,
    REG_GPU_COMMAND = 3'd3,
    REG_GPU_CONTROL = 3'd4,
    REG_DMA_BLOCK   = 3'd5,
    REG_IRQ_STATUS  = 3'd6,
    REG_IRQ_MASK    = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [ADDR_W-1:0] cd_block_addr;
    logic [ADDR_W-1:0] pad_block_addr;
    logic [ADDR_W-1:0] dec_block_addr;
    logic [ADDR_W-1:0] gpu_command_address;
    logic [ADDR_W-1:0] gpu_control_address;
    logic [ADDR_W-1:0] dma_block_addr;
    logic [ADDR_W-1:0] irq_status_address;
    logic [ADDR_W-1:0] irq_mask_address;
  } cfg_t;

  // Decoded item handed from the front part to the back part.
  typedef struct packed {
    logic              clear;
    logic [ADDR_W-1:0] address;
  } op_t;

  // True when addr lies in [base, base + span), without wrapping at the top.
  function automatic logic in_block(input logic [ADDR_W-1:0] addr,
                                    input logic [ADDR_W-1:0] base,
                                    input logic [ADDR_W:0]   span);
    logic [ADDR_W:0] a_ext;
    logic [ADDR_W:0] b_ext;
    a_ext = {1'b0, addr};
    b_ext = {1'b0, base};
    return (a_ext >= b_ext) && (a_ext < (b_ext + span));
  endfunction

  // Priority classification of a dominant address; first match wins.
  function automatic reason_e classify(input logic [ADDR_W-1:0] addr,
                                       input cfg_t              cfg);
    reason_e r;
    if (in_block(addr, cfg.cd_block_addr, CDROM_SPAN)) begin
      r = REASON_CDROM;
    end else if (in_block(addr, cfg.pad_block_addr, CONTROLLER_SPAN)) begin
      r = REASON_CONTROLLER;
    end else if (in_block(addr, cfg.dec_block_addr, MDEC_SPAN)) begin
      r = REASON_DECODER;
    end else if (addr == cfg.gpu_command_address || addr == cfg.gpu_control_address) begin
      r = REASON_GPU_BUSY;
    end else if (in_block(addr, cfg.dma_block_addr, DMA_SPAN)) begin
      r = REASON_DMA_WAIT;
    end else if (addr == cfg.irq_status_address || addr == cfg.irq_mask_address) begin
      r = REASON_IRQ;
    end else begin
      r = REASON_UNKNOWN;
    end
    return r;
  endfunction

endpackage

[hdl/rplc_in_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Register poll loop classifier input channel
// Valid/ready channel carrying one access or clear item.
// ----------------------------------------------------------------------------
interface rplc_in_if;
  logic                        valid;
  logic                        ready;
  logic                        kind;
  logic [rplc_pkg::ADDR_W-1:0] address;

  modport source (output valid, output kind, output address, input ready);
  modport sink   (input valid, input kind, input address, output ready);
endinterface

[hdl/rplc_out_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Register poll loop classifier output channel
// Valid/ready channel carrying one stall reason per item.
// ----------------------------------------------------------------------------
interface rplc_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] reason;

  modport source (output valid, output reason, input ready);
  modport sink   (input valid, input reason, output ready);
endinterface

[hdl/rplc_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Register poll loop classifier front part
// Accepts input items, decodes their kind and holds them in a short queue
// for the back part.
// ----------------------------------------------------------------------------
module rplc_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  rplc_in_if.sink            in_i,
  output logic               q_valid_o,
  output rplc_pkg::op_t      q_op_o,
  input  logic               q_pop_i
);

  rplc_pkg::op_t                     queue_q [rplc_pkg::QUEUE_DEPTH];
  logic [rplc_pkg::QPTR_W-1:0]       wr_ptr_q, wr_ptr_d;
  logic [rplc_pkg::QPTR_W-1:0]       rd_ptr_q, rd_ptr_d;
  logic [rplc_pkg::QCNT_W-1:0]       count_q, count_d;
  logic                              push;
  logic                              pop;
  rplc_pkg::op_t                     op_in;

  // Decode the incoming item.
  always_comb begin
    op_in.clear   = (rplc_pkg::kind_e'(in_i.kind) == rplc_pkg::KIND_CLEAR);
    op_in.address = in_i.address;
  end

  assign in_i.ready = (count_q != rplc_pkg::QCNT_W'(rplc_pkg::QUEUE_DEPTH));
  assign push       = in_i.valid && in_i.ready;
  assign q_valid_o  = (count_q != '0);
  assign pop        = q_pop_i && q_valid_o;
  assign q_op_o     = queue_q[rd_ptr_q];

  // Pointer and occupancy updates.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == rplc_pkg::QPTR_W'(rplc_pkg::QUEUE_DEPTH - 1)) ?
                 '0 : wr_ptr_q + rplc_pkg::QPTR_W'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == rplc_pkg::QPTR_W'(rplc_pkg::QUEUE_DEPTH - 1)) ?
                 '0 : rd_ptr_q + rplc_pkg::QPTR_W'(1);
    end
    if (push && !pop) begin
      count_d = count_q + rplc_pkg::QCNT_W'(1);
    end else if (pop && !push) begin
      count_d = count_q - rplc_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Queue storage; payload needs no reset.
  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= op_in;
    end
  end

endmodule

[hdl/rplc_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Register poll loop classifier back part
// Keeps the address history, scans it one candidate per cycle for a
// dominant address, classifies that address and drives the result register.
// ----------------------------------------------------------------------------
module rplc_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_valid_i,
  input  rplc_pkg::op_t      q_op_i,
  output logic               q_pop_o,
  input  rplc_pkg::cfg_t     cfg_i,
  rplc_out_if.source         out_o
);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SCAN  = 3'b010,
    ST_CLASS = 3'b100
  } state_e;

  state_e                          state_q, state_d;
  logic [rplc_pkg::ADDR_W-1:0]     hist_q [rplc_pkg::WINDOW];
  logic [rplc_pkg::CNT_W-1:0]      fill_q, fill_d;
  logic [rplc_pkg::CNT_W-1:0]      fill_next;
  logic [rplc_pkg::SLOT_W-1:0]     idx_q, idx_d;
  logic [rplc_pkg::ADDR_W-1:0]     dom_q, dom_d;
  logic                            hit_q, hit_d;
  logic                            shift_in;
  logic                            out_valid_q;
  rplc_pkg::reason_e               out_reason_q, res_d;
  logic                            load_res;
  logic                            out_free;
  logic [rplc_pkg::ADDR_W-1:0]     cand;
  logic [rplc_pkg::WINDOW-1:0]     match;
  logic [rplc_pkg::CNT_W-1:0]      match_cnt;
  logic [rplc_pkg::CNT_W+1:0]      lhs;
  logic [rplc_pkg::CNT_W+1:0]      rhs;
  logic                            dominant;
  logic                            last;

  assign out_free  = !out_valid_q || out_o.ready;
  assign fill_next = (fill_q == rplc_pkg::CNT_W'(rplc_pkg::WINDOW)) ?
                     fill_q : fill_q + rplc_pkg::CNT_W'(1);

  // Compare the current candidate with every live history entry.
  assign cand = hist_q[idx_q];
  always_comb begin
    for (int j = 0; j < rplc_pkg::WINDOW; j++) begin
      match[j] = (hist_q[j] == cand) && (rplc_pkg::CNT_W'(j) < fill_q);
    end
  end

  always_comb begin
    match_cnt = '0;
    for (int j = 0; j < rplc_pkg::WINDOW; j++) begin
      match_cnt = match_cnt + rplc_pkg::CNT_W'(match[j]);
    end
  end

  // Dominance test: count * 4 >= fill * 3, fill being the live history length.
  assign lhs      = {match_cnt, 2'b00};
  assign rhs      = (rplc_pkg::CNT_W + 2)'({fill_q, 1'b0}) + (rplc_pkg::CNT_W + 2)'(fill_q);
  assign dominant = (lhs >= rhs);
  assign last     = (rplc_pkg::CNT_W'(idx_q) == fill_q - rplc_pkg::CNT_W'(1));

  // Sequencer.
  always_comb begin
    state_d  = state_q;
    fill_d   = fill_q;
    idx_d    = idx_q;
    dom_d    = dom_q;
    hit_d    = hit_q;
    q_pop_o  = 1'b0;
    shift_in = 1'b0;
    load_res = 1'b0;
    res_d    = rplc_pkg::REASON_UNKNOWN;
    unique case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          if (q_op_i.clear) begin
            if (out_free) begin
              q_pop_o  = 1'b1;
              fill_d   = '0;
              load_res = 1'b1;
            end
          end else if (fill_next < rplc_pkg::CNT_W'(rplc_pkg::MIN_FILL)) begin
            if (out_free) begin
              q_pop_o  = 1'b1;
              shift_in = 1'b1;
              fill_d   = fill_next;
              load_res = 1'b1;
            end
          end else begin
            q_pop_o  = 1'b1;
            shift_in = 1'b1;
            fill_d   = fill_next;
            idx_d    = '0;
            state_d  = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (dominant) begin
          dom_d   = cand;
          hit_d   = 1'b1;
          state_d = ST_CLASS;
        end else if (last) begin
          hit_d   = 1'b0;
          state_d = ST_CLASS;
        end else begin
          idx_d = idx_q + rplc_pkg::SLOT_W'(1);
        end
      end
      ST_CLASS: begin
        if (out_free) begin
          load_res = 1'b1;
          res_d    = hit_q ? rplc_pkg::classify(dom_q, cfg_i) : rplc_pkg::REASON_UNKNOWN;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fill_q      <= '0;
      idx_q       <= '0;
      hit_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      idx_q   <= idx_d;
      hit_q   <= hit_d;
      if (load_res) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // History shift line, newest entry at the front, and payload registers.
  always_ff @(posedge clk_i) begin
    dom_q <= dom_d;
    if (load_res) begin
      out_reason_q <= res_d;
    end
    if (shift_in) begin
      hist_q[0] <= q_op_i.address;
      for (int k = 1; k < rplc_pkg::WINDOW; k++) begin
        hist_q[k] <= hist_q[k-1];
      end
    end
  end

  assign out_o.valid  = out_valid_q;
  assign out_o.reason = out_reason_q;

`ifndef NO_ASSERTIONS
  // The fill count saturates at the history depth.
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= rplc_pkg::CNT_W'(rplc_pkg::WINDOW))
    else $error("fill count above history depth");

  // The scan never looks past the live part of the history.
  a_scan_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SCAN |-> (rplc_pkg::CNT_W'(idx_q) < fill_q &&
                            fill_q >= rplc_pkg::CNT_W'(rplc_pkg::MIN_FILL)))
    else $error("scan index outside the live history");

  // A clear item empties the history.
  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o && q_valid_i && q_op_i.clear |=> fill_q == '0)
    else $error("history not emptied after clear");

  // A known reason is only reported with enough history recorded.
  a_known_needs_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_reason_q != rplc_pkg::REASON_UNKNOWN |->
      fill_q >= rplc_pkg::CNT_W'(rplc_pkg::MIN_FILL))
    else $error("known reason with too little history");
`endif

endmodule

[hdl/register_poll_loop_classifier_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Register poll loop classifier
// Records bus register accesses and reports why the bus master appears to be
// stalled in a polling loop.
// ----------------------------------------------------------------------------
// Usage:
//   in_i  : one transfer per item; kind 0 records an access address, kind 1
//           clears the access history.
//   out_o : one transfer per item carrying the stall reason (0 unknown,
//           1 CD-ROM, 2 controller, 3 decoder, 4 GPU busy, 5 DMA, 6 IRQ).
//   cfg_* : write-only register port for the eight device addresses; write
//           only while no item is in flight.
// Flow: a two-entry queue follows the input. A clear item, or an access
// that leaves fewer than four recorded, is handled in the idle state of
// the back part; any other access passes through the scan state, which
// checks k history entries (1 to 16, one per cycle), and then the classify
// state. The result is registered.
// Reset clears the history fill count, the queue and the output valid, and
// loads the default device addresses. When the receiver stalls the result is
// held; the queue keeps accepting until it holds two items.
// ----------------------------------------------------------------------------
module register_poll_loop_classifier_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  rplc_in_if.sink                     in_i,
  rplc_out_if.source                  out_o,
  input  logic                        cfg_we_i,
  input  logic [2:0]                  cfg_idx_i,
  input  logic [rplc_pkg::ADDR_W-1:0] cfg_wdata_i
);

  rplc_pkg::cfg_t cfg_q;
  logic           q_valid;
  rplc_pkg::op_t  q_op;
  logic           q_pop;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cd_block_addr       <= rplc_pkg::CD_BLOCK_RST;
      cfg_q.pad_block_addr      <= rplc_pkg::CTRL_BASE_RST;
      cfg_q.dec_block_addr      <= rplc_pkg::DEC_BLOCK_RST;
      cfg_q.gpu_command_address <= rplc_pkg::GPU_CMD_RST;
      cfg_q.gpu_control_address <= rplc_pkg::GPU_CTRL_RST;
      cfg_q.dma_block_addr      <= rplc_pkg::DMA_BLOCK_RST;
      cfg_q.irq_status_address  <= rplc_pkg::IRQ_STATUS_RST;
      cfg_q.irq_mask_address    <= rplc_pkg::IRQ_MASK_RST;
    end else if (cfg_we_i) begin
      unique case (rplc_pkg::cfg_idx_e'(cfg_idx_i))
        rplc_pkg::REG_CD_BLOCK:    cfg_q.cd_block_addr       <= cfg_wdata_i;
        rplc_pkg::REG_PAD_BLOCK:   cfg_q.pad_block_addr      <= cfg_wdata_i;
        rplc_pkg::REG_DEC_BLOCK:   cfg_q.dec_block_addr      <= cfg_wdata_i;
        rplc_pkg::REG_GPU_COMMAND: cfg_q.gpu_command_address <= cfg_wdata_i;
        rplc_pkg::REG_GPU_CONTROL: cfg_q.gpu_control_address <= cfg_wdata_i;
        rplc_pkg::REG_DMA_BLOCK:   cfg_q.dma_block_addr      <= cfg_wdata_i;
        rplc_pkg::REG_IRQ_STATUS:  cfg_q.irq_status_address  <= cfg_wdata_i;
        rplc_pkg::REG_IRQ_MASK:    cfg_q.irq_mask_address    <= cfg_wdata_i;
      endcase
    end
  end

  // Front part: accept, decode and queue.
  rplc_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .q_valid_o (q_valid),
    .q_op_o    (q_op),
    .q_pop_i   (q_pop)
  );

  // Back part: history, scan, classification and result register.
  rplc_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_op_i    (q_op),
    .q_pop_o   (q_pop),
    .cfg_i     (cfg_q),
    .out_o     (out_o)
  );

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Register poll loop classifier testbench
// Drives access and clear items through the valid/ready input channel and
// checks every stall reason against a scoreboard that keeps its own copy of
// the address history and the device address registers. Several register
// settings are used, including addresses at both ends of the address space,
// and both channels idle at random, with a long receiver hold-off in two of
// the phases that fills the block and stalls its input.
// ----------------------------------------------------------------------------
module tb_top;
  import rplc_pkg::*;

  // Run control.
  localparam int unsigned HOLD_OFF_CYCLES = 200;
  localparam int unsigned SETTLE_CYCLES   = 25;
  localparam int unsigned DRAIN_LIMIT     = 20000;

  // Scoreboard: predicts the stall reason of each accepted item and checks
  // the results in order.
  class stall_reason_scoreboard;
    logic [ADDR_W-1:0] history [WINDOW];
    logic [CNT_W-1:0]  fill;
    logic [SLOT_W-1:0] slot;
    cfg_t              regs;
    reason_e           expected_reasons [$];
    int                errors;

    function new();
      fill   = '0;
      slot   = '0;
      errors = 0;
      regs   = {CD_BLOCK_RST, CTRL_BASE_RST, DEC_BLOCK_RST, GPU_CMD_RST,
                GPU_CTRL_RST, DMA_BLOCK_RST, IRQ_STATUS_RST, IRQ_MASK_RST};
    endfunction

    function void set_register(cfg_idx_e idx, logic [ADDR_W-1:0] value);
      case (idx)
        REG_CD_BLOCK:    regs.cd_block_addr       = value;
        REG_PAD_BLOCK:   regs.pad_block_addr      = value;
        REG_DEC_BLOCK:   regs.dec_block_addr      = value;
        REG_GPU_COMMAND: regs.gpu_command_address = value;
        REG_GPU_CONTROL: regs.gpu_control_address = value;
        REG_DMA_BLOCK:   regs.dma_block_addr      = value;
        REG_IRQ_STATUS:  regs.irq_status_address  = value;
        default:         regs.irq_mask_address    = value;
      endcase
    endfunction

    // Range test without wrap round at the top of the address space.
    function bit in_span(logic [ADDR_W-1:0] addr, logic [ADDR_W-1:0] base,
                         int unsigned span);
      logic [ADDR_W:0] a;
      logic [ADDR_W:0] b;
      a = {1'b0, addr};
      b = {1'b0, base};
      return (a >= b) && (a < b + (ADDR_W + 1)'(span));
    endfunction

    // Device targets are tried in priority order; the first match wins.
    function reason_e device_of(logic [ADDR_W-1:0] addr);
      if (in_span(addr, regs.cd_block_addr, 4)) return REASON_CDROM;
      if (in_span(addr, regs.pad_block_addr, 16)) return REASON_CONTROLLER;
      if (in_span(addr, regs.dec_block_addr, 8)) return REASON_DECODER;
      if (addr == regs.gpu_command_address || addr == regs.gpu_control_address)
        return REASON_GPU_BUSY;
      if (in_span(addr, regs.dma_block_addr, 128)) return REASON_DMA_WAIT;
      if (addr == regs.irq_status_address || addr == regs.irq_mask_address)
        return REASON_IRQ;
      return REASON_UNKNOWN;
    endfunction

    function logic [ADDR_W-1:0] recent(int unsigned age);
      return history[(int'(slot) + 2 * WINDOW - 1 - age) % WINDOW];
    endfunction

    // Updates the history with one item and works out its stall reason.
    function reason_e predict_reason(kind_e kind, logic [ADDR_W-1:0] addr);
      int unsigned span;
      int unsigned hits;
      logic [ADDR_W-1:0] candidate;
      if (kind == KIND_CLEAR) begin
        fill = '0;
        slot = '0;
        return REASON_UNKNOWN;
      end
      history[slot] = addr;
      slot = slot + 1'b1;
      if (fill < WINDOW) fill = fill + 1'b1;
      if (fill < MIN_FILL) return REASON_UNKNOWN;
      span = (fill < WINDOW) ? fill : WINDOW;
      for (int unsigned i = 0; i < span; i++) begin
        candidate = recent(i);
        hits = 0;
        for (int unsigned j = 0; j < span; j++) begin
          if (recent(j) == candidate) hits++;
        end
        if (hits * 4 >= span * 3) return device_of(candidate);
      end
      return REASON_UNKNOWN;
    endfunction

    function void note_item(kind_e kind, logic [ADDR_W-1:0] addr);
      expected_reasons.push_back(predict_reason(kind, addr));
    endfunction

    function int pending();
      return expected_reasons.size();
    endfunction

    task report_mismatch(string what);
      $display("[%0t] mismatch: %s", $realtime, what);
      errors++;
    endtask

    task check_result(logic [2:0] got);
      reason_e want;
      if (expected_reasons.size() == 0) begin
        report_mismatch($sformatf("unexpected result, reason %0d", got));
      end else begin
        want = expected_reasons.pop_front();
        if (got !== want)
          report_mismatch($sformatf("reason %0d, expected %0d", got, want));
      end
    endtask
  endclass

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic [2:0]          cfg_idx;
  logic [ADDR_W-1:0]   cfg_wdata;
  bit                  hold_off_request;
  bit                  no_idle;
  stall_reason_scoreboard sb;

  rplc_in_if  in_bus ();
  rplc_out_if out_bus ();

  register_poll_loop_classifier_core uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_i        (in_bus),
    .out_o       (out_bus),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  // Clock and the single reset at the start of the run.
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    rst_n = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
  end

  // Gap lengths: mostly none or short, now and then long.
  function automatic int unsigned idle_gap();
    int unsigned r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Receiver: random ready gaps, plus a long hold-off whenever one is asked.
  initial begin : receiver
    int unsigned gap;
    int unsigned run;
    out_bus.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_off_request) begin
        out_bus.ready = 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
        hold_off_request = 1'b0;
      end
      gap = idle_gap();
      if (gap > 0) begin
        out_bus.ready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_bus.ready = 1'b1;
      run = $urandom_range(1, 12);
      repeat (run - 1) @(negedge clk);
    end
  end

  // Result monitor: every output transfer is checked in order.
  always @(posedge clk) begin
    if (rst_n && out_bus.valid === 1'b1 && out_bus.ready) sb.check_result(out_bus.reason);
  end

  // Offers one item after a random gap and returns at the edge of its transfer.
  task automatic send_item(kind_e kind, logic [ADDR_W-1:0] addr);
    int unsigned gap;
    gap = idle_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_bus.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_bus.valid   = 1'b1;
    in_bus.kind    = kind;
    in_bus.address = addr;
    do @(posedge clk); while (!in_bus.ready);
    sb.note_item(kind, addr);
  endtask

  // Waits until every result has arrived and the block has settled.
  task automatic drain_results();
    int unsigned waited;
    waited = 0;
    @(negedge clk);
    in_bus.valid = 1'b0;
    while (sb.pending() > 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Writes all eight device address registers while the block is idle.
  task automatic apply_settings(cfg_t setting);
    logic [ADDR_W-1:0] values [8];
    cfg_idx_e idx;
    values = '{setting.cd_block_addr, setting.pad_block_addr,
               setting.dec_block_addr, setting.gpu_command_address,
               setting.gpu_control_address, setting.dma_block_addr,
               setting.irq_status_address, setting.irq_mask_address};
    drain_results();
    for (int i = 0; i < 8; i++) begin
      idx       = cfg_idx_e'(i);
      cfg_we    = 1'b1;
      cfg_idx   = idx;
      cfg_wdata = values[i];
      sb.set_register(idx, values[i]);
      @(negedge clk);
    end
    cfg_we = 1'b0;
  endtask

  // An address at or near one of the current targets, just outside a block or port, or random.
  function automatic logic [ADDR_W-1:0] pick_target();
    case ($urandom_range(0, 11))
      0:  return sb.regs.cd_block_addr + $urandom_range(0, 4);
      1:  return sb.regs.pad_block_addr + $urandom_range(0, 16);
      2:  return sb.regs.dec_block_addr + $urandom_range(0, 8);
      3:  return sb.regs.gpu_command_address;
      4:  return sb.regs.gpu_control_address;
      5:  return sb.regs.dma_block_addr + $urandom_range(0, 128);
      6:  return sb.regs.irq_status_address;
      7:  return sb.regs.irq_mask_address;
      8:  return sb.regs.cd_block_addr - 1;
      9:  return sb.regs.gpu_control_address + 1;
      10: return sb.regs.dma_block_addr - $urandom_range(1, 3);
      default: return $urandom;
    endcase
  endfunction

  // A clear followed by four polls of one address: the first three are too
  // few to classify, the fourth is.
  task automatic poll_probe(logic [ADDR_W-1:0] addr);
    send_item(KIND_CLEAR, $urandom);
    repeat (4) send_item(KIND_ACCESS, addr);
  endtask

  // Mostly polling loops on one target with a little noise, plus clears,
  // stray accesses and broken loops.
  task automatic run_random(int unsigned count);
    int unsigned done;
    int unsigned sel;
    int unsigned len;
    logic [ADDR_W-1:0] target;
    done = 0;
    while (done < count) begin
      sel = $urandom_range(0, 99);
      if (sel < 8) begin
        send_item(KIND_CLEAR, $urandom);
        done++;
      end else if (sel < 20) begin
        send_item(KIND_ACCESS, $urandom);
        done++;
      end else begin
        target = pick_target();
        len    = $urandom_range(3, 20);
        for (int unsigned k = 0; k < len; k++) begin
          sel = $urandom_range(0, 99);
          if (sel < 3) send_item(KIND_CLEAR, $urandom);
          else if (sel < 80) send_item(KIND_ACCESS, target);
          else if (sel < 90) send_item(KIND_ACCESS, pick_target());
          else send_item(KIND_ACCESS, $urandom);
        end
        done += len;
      end
    end
  endtask

  // Register settings built around one random base so that blocks overlap.
  function automatic cfg_t clustered_setting();
    cfg_t s;
    logic [ADDR_W-1:0] b;
    b = $urandom;
    s.cd_block_addr       = b + $urandom_range(0, 256);
    s.pad_block_addr      = b + $urandom_range(0, 256);
    s.dec_block_addr      = b + $urandom_range(0, 256);
    s.gpu_command_address = b + $urandom_range(0, 256);
    s.gpu_control_address = b + $urandom_range(0, 256);
    s.dma_block_addr      = b + $urandom_range(0, 256);
    s.irq_status_address  = b + $urandom_range(0, 256);
    s.irq_mask_address    = b + $urandom_range(0, 256);
    return s;
  endfunction

  // Main sequence of phases.
  initial begin : stimulus
    cfg_t defaults;
    cfg_t setting;
    sb               = new();
    hold_off_request = 1'b0;
    no_idle          = 1'b0;
    in_bus.valid     = 1'b0;
    in_bus.kind      = KIND_ACCESS;
    in_bus.address   = '0;
    cfg_we           = 1'b0;
    cfg_idx          = REG_CD_BLOCK;
    cfg_wdata        = '0;
    defaults = {CD_BLOCK_RST, CTRL_BASE_RST, DEC_BLOCK_RST, GPU_CMD_RST,
                GPU_CTRL_RST, DMA_BLOCK_RST, IRQ_STATUS_RST, IRQ_MASK_RST};
    @(posedge rst_n);

    // Directed: last address of each block and an exact port at reset values.
    poll_probe(sb.regs.cd_block_addr + 3);
    poll_probe(sb.regs.pad_block_addr + 15);
    poll_probe(sb.regs.dec_block_addr + 7);
    poll_probe(sb.regs.gpu_command_address);
    poll_probe(sb.regs.dma_block_addr + 127);

    // Default addresses written back, with a long hold-off part way through.
    apply_settings(defaults);
    run_random(120);
    hold_off_request = 1'b1;
    run_random(230);

    // Blocks at the top of the address space: no wrap round to zero, and
    // overlapping blocks resolved by priority.
    setting.cd_block_addr       = 32'hFFFF_FFFE;
    setting.pad_block_addr      = 32'hFFFF_FFF0;
    setting.dec_block_addr      = 32'hFFFF_FFF8;
    setting.gpu_command_address = 32'hFFFF_FFFF;
    setting.gpu_control_address = 32'h0000_0000;
    setting.dma_block_addr      = 32'hFFFF_FF80;
    setting.irq_status_address  = 32'hFFFF_FFFF;
    setting.irq_mask_address    = 32'hFFFF_FFFD;
    apply_settings(setting);
    no_idle = 1'b1;
    send_item(KIND_CLEAR, '0);
    repeat (4) send_item(KIND_ACCESS, 32'h0000_0001);
    run_random(300);
    no_idle = 1'b0;

    // Everything at zero.
    apply_settings('0);
    run_random(250);

    // Random overlapping blocks.
    apply_settings(clustered_setting());
    run_random(180);
    apply_settings(clustered_setting());
    no_idle = 1'b1;
    run_random(170);
    no_idle = 1'b0;

    // Fully random addresses, then the defaults again under pressure.
    setting = {$urandom, $urandom, $urandom, $urandom,
               $urandom, $urandom, $urandom, $urandom};
    apply_settings(setting);
    run_random(300);
    apply_settings(defaults);
    run_random(60);
    hold_off_request = 1'b1;
    run_random(140);

    // Let the last results out, then give the verdict.
    drain_results();
    if (sb.pending() > 0)
      sb.report_mismatch($sformatf("%0d expected results never arrived", sb.pending()));
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog for a block that hangs.
  initial begin
    #3000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

[filelist.f]
hdl/rplc_pkg.sv
hdl/rplc_in_if.sv
hdl/rplc_out_if.sv
hdl/rplc_front.sv
hdl/rplc_back.sv
hdl/register_poll_loop_classifier_core.sv
tb/tb_top.sv
